### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Antecedent holds -> consequent holds after the delay given by dly.
`define ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("assertion failed: delayed implication");

`endif

### rtl/hsv2rgb_pkg.sv
// Package: payload types and constants of the HSV to RGB converter.
package hsv2rgb_pkg;

    localparam int HUE_W  = 16;
    localparam int FRAC_W = 13;
    localparam int CHAN_W = 8;

    localparam int DEFAULT_FRACTION_BITS = 12;

    localparam int HUE_OFFSET = 34560;
    localparam int HUE_SECTOR = 960;
    localparam int CHAN_MAX   = 255;
    localparam int RECIP15    = 4370;
    localparam int RECIP6     = 43;
    localparam int PIPE_DEPTH = 7;

    localparam logic [2:0] SECTOR_0 = 3'd0;
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;

    typedef struct packed {
        logic signed [HUE_W-1:0] hue;
        logic [FRAC_W-1:0]       saturation;
        logic [FRAC_W-1:0]       brightness;
    } hsv_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } rgba_t;

endpackage

### rtl/hsv2rgb_byte.sv
// Two-stage scaling of a channel numerator to a rounded 8-bit channel.
module hsv2rgb_byte
    import hsv2rgb_pkg::*;
#(
    parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
)(
    input  logic                        clk,
    input  logic [2*FRACTION_BITS+10:0] num,
    output logic [CHAN_W-1:0]           chan
);
    localparam int PW  = 2 * FRACTION_BITS + 11;
    localparam int AW  = PW + 8;
    localparam int ZSH = 6 + 2 * FRACTION_BITS;
    localparam int ZW  = AW - ZSH;
    localparam int MW  = ZW + 13;
    localparam logic [AW-1:0] HALF = AW'(HUE_SECTOR / 2) << (2 * FRACTION_BITS);

    logic [AW-1:0]     scaled;
    logic [ZW-1:0]     z_next;
    logic [ZW-1:0]     z_reg;
    logic [MW-1:0]     prod;
    logic [CHAN_W-1:0] chan_next;
    logic [CHAN_W-1:0] chan_reg;

    // num*255 + den/2, then divide by 960*2^(2F) as a shift and a divide by 15
    always_comb
    begin
        scaled    = (AW'(num) << 8) - AW'(num) + HALF;
        z_next    = scaled[AW-1:ZSH];
        prod      = MW'(z_reg) * MW'(RECIP15);
        chan_next = prod[23:16];
    end

    always_ff @(posedge clk)
    begin
        z_reg    <= z_next;
        chan_reg <= chan_next;
    end

    assign chan = chan_reg;

endmodule

### rtl/hsv_to_rgb_converter.sv
// Top level: pipelined HSV to RGBA color converter.
//
//  channel  | signals           | handshake
//  ---------+-------------------+----------------------------------------
//  input    | start, busy, hsv  | taken at a clock edge with start && !busy
//  result   | done, rgba        | one-cycle strobe, receiver always takes
//
// Seven register stages; one transaction per clock. The stages follow the
// multiplier chain: hue sector split, s*r terms, v products, byte scaling.
// busy stays low: the result side never stalls, so the pipe never holds.
// Reset clears the valid bits only; data registers are not reset.
module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
#(
    parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
)(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  hsv_t  hsv,
    output logic  done,
    output rgba_t rgba
);
    localparam int W  = FRACTION_BITS + 1;
    localparam int CW = (FRAC_W > W) ? FRAC_W : W;
    localparam int NW = FRACTION_BITS + 10;
    localparam int PW = 2 * FRACTION_BITS + 11;
    localparam int GW = W + 8;
    localparam logic [CW-1:0] ONE_C  = CW'(1) << FRACTION_BITS;
    localparam logic [W-1:0]  ONE    = W'(1) << FRACTION_BITS;
    localparam logic [NW-1:0] ONE960 = NW'(HUE_SECTOR) << FRACTION_BITS;

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;
    logic                  take;

    // stage 1
    logic [CW-1:0] s_ext, v_ext;
    logic [W-1:0]  s1_next, v1_next, s1_reg, v1_reg;
    logic [16:0]   x1_next, x1_reg;
    logic [23:0]   qp;
    logic [6:0]    q1_next, q1_reg;
    // stage 2
    logic [16:0]   q960;
    logic [16:0]   xdiff;
    logic [12:0]   tp;
    logic [6:0]    secw;
    logic [W-1:0]  s2_reg, v2_reg;
    logic [9:0]    r2_next, r2_reg;
    logic [2:0]    sec2_next, sec2_reg;
    // stage 3
    logic [9:0]    rc;
    logic [NW-1:0] a3_next, b3_next, c3_next, a3_reg, b3_reg, c3_reg;
    logic [W-1:0]  v3_reg;
    logic [2:0]    sec3_reg;
    // stage 4
    logic [PW-1:0] nq4_next, nt4_next, np4_next, nv4_next;
    logic [PW-1:0] nq4_reg, nt4_reg, np4_reg, nv4_reg;
    logic [GW-1:0] gp;
    logic [CHAN_W-1:0] g4_next, g4_reg;
    logic [2:0]    sec4_reg;
    // stage 5
    logic [PW-1:0] cr5_next, cg5_next, cb5_next, cr5_reg, cg5_reg, cb5_reg;
    logic [CHAN_W-1:0] g5_reg, g6_reg, g7_reg;
    logic [PIPE_DEPTH-1:0] grey_reg;
    logic [CHAN_W-1:0] red_b, green_b, blue_b;

    assign busy = 1'b0;
    assign take = start && !busy;

    always_comb
    begin
        vld_next = {vld_reg[PIPE_DEPTH-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: clamp, hue offset, coarse sector count x/960
    always_comb
    begin
        s_ext   = CW'(hsv.saturation);
        v_ext   = CW'(hsv.brightness);
        s1_next = (s_ext > ONE_C) ? ONE : s_ext[W-1:0];
        v1_next = (v_ext > ONE_C) ? ONE : v_ext[W-1:0];
        x1_next = 17'({hsv.hue[HUE_W-1], hsv.hue}) + 17'(HUE_OFFSET);
        qp      = 24'(x1_next[16:6]) * 24'(RECIP15);
        q1_next = qp[22:16];
    end

    // stage 2: position inside sector, sector = count mod 6
    always_comb
    begin
        q960      = 17'(q1_reg) * 17'(HUE_SECTOR);
        xdiff     = x1_reg - q960;
        r2_next   = xdiff[9:0];
        tp        = 13'(q1_reg) * 13'(RECIP6);
        secw      = q1_reg - 7'(tp[12:8]) * 7'd6;
        sec2_next = secw[2:0];
    end

    // stage 3: q, t and p factors scaled by 960
    always_comb
    begin
        rc      = 10'(HUE_SECTOR) - r2_reg;
        a3_next = ONE960 - NW'(s2_reg) * NW'(r2_reg);
        b3_next = ONE960 - NW'(s2_reg) * NW'(rc);
        c3_next = NW'(ONE - s2_reg) * NW'(HUE_SECTOR);
    end

    // stage 4: multiply by value
    always_comb
    begin
        nq4_next = PW'(v3_reg) * PW'(a3_reg);
        nt4_next = PW'(v3_reg) * PW'(b3_reg);
        np4_next = PW'(v3_reg) * PW'(c3_reg);
        nv4_next = PW'(v3_reg) * PW'(ONE960);
        gp       = GW'(v3_reg) * GW'(CHAN_MAX);
        g4_next  = gp[FRACTION_BITS+7:FRACTION_BITS];
    end

    // stage 5: route by sector
    always_comb
    begin
        case (sec4_reg)
            SECTOR_0:
            begin
                cr5_next = nv4_reg; cg5_next = nt4_reg; cb5_next = np4_reg;
            end
            SECTOR_1:
            begin
                cr5_next = nq4_reg; cg5_next = nv4_reg; cb5_next = np4_reg;
            end
            SECTOR_2:
            begin
                cr5_next = np4_reg; cg5_next = nv4_reg; cb5_next = nt4_reg;
            end
            SECTOR_3:
            begin
                cr5_next = np4_reg; cg5_next = nq4_reg; cb5_next = nv4_reg;
            end
            SECTOR_4:
            begin
                cr5_next = nt4_reg; cg5_next = np4_reg; cb5_next = nv4_reg;
            end
            default:
            begin
                cr5_next = nv4_reg; cg5_next = np4_reg; cb5_next = nq4_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s1_reg   <= s1_next;
        v1_reg   <= v1_next;
        x1_reg   <= x1_next;
        q1_reg   <= q1_next;
        s2_reg   <= s1_reg;
        v2_reg   <= v1_reg;
        r2_reg   <= r2_next;
        sec2_reg <= sec2_next;
        a3_reg   <= a3_next;
        b3_reg   <= b3_next;
        c3_reg   <= c3_next;
        v3_reg   <= v2_reg;
        sec3_reg <= sec2_reg;
        nq4_reg  <= nq4_next;
        nt4_reg  <= nt4_next;
        np4_reg  <= np4_next;
        nv4_reg  <= nv4_next;
        g4_reg   <= g4_next;
        sec4_reg <= sec3_reg;
        cr5_reg  <= cr5_next;
        cg5_reg  <= cg5_next;
        cb5_reg  <= cb5_next;
        g5_reg   <= g4_reg;
        g6_reg   <= g5_reg;
        g7_reg   <= g6_reg;
        grey_reg <= {grey_reg[PIPE_DEPTH-2:0], (s1_next == '0)};
    end

    hsv2rgb_byte #(.FRACTION_BITS(FRACTION_BITS)) u_red
    (
        .clk  (clk),
        .num  (cr5_reg),
        .chan (red_b)
    );

    hsv2rgb_byte #(.FRACTION_BITS(FRACTION_BITS)) u_green
    (
        .clk  (clk),
        .num  (cg5_reg),
        .chan (green_b)
    );

    hsv2rgb_byte #(.FRACTION_BITS(FRACTION_BITS)) u_blue
    (
        .clk  (clk),
        .num  (cb5_reg),
        .chan (blue_b)
    );

    // zero saturation: truncated grey
    assign done       = vld_reg[PIPE_DEPTH-1];
    assign rgba.red   = grey_reg[PIPE_DEPTH-1] ? g7_reg : red_b;
    assign rgba.green = grey_reg[PIPE_DEPTH-1] ? g7_reg : green_b;
    assign rgba.blue  = grey_reg[PIPE_DEPTH-1] ? g7_reg : blue_b;
    assign rgba.alpha = CHAN_W'(CHAN_MAX);

endmodule

### rtl/hsv2rgb_checker.sv
// Port-level checker for the HSV to RGB converter, bound to the top level.
`include "assert_macros.svh"

module hsv2rgb_checker
    import hsv2rgb_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  start,
    input logic  busy,
    input hsv_t  hsv,
    input logic  done,
    input rgba_t rgba
);
    logic grey_in;
    logic rgb_equal;

    assign grey_in   = (hsv.saturation == '0);
    assign rgb_equal = (rgba.red == rgba.green) && (rgba.green == rgba.blue);

    `ASSERT_IMPLIES(a_never_busy, clk, rst_n, 1'b1, !busy)
    `ASSERT_DELAY(a_latency, clk, rst_n, start && !busy, 7, done)
    `ASSERT_IMPLIES(a_no_spurious, clk, rst_n, done, $past(start && !busy, PIPE_DEPTH))
    `ASSERT_IMPLIES(a_grey_equal, clk, rst_n, done && $past(grey_in, PIPE_DEPTH), rgb_equal)
    `ASSERT_IMPLIES(a_alpha_opaque, clk, rst_n, done, rgba.alpha == CHAN_W'(CHAN_MAX))

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .hsv   (hsv),
    .done  (done),
    .rgba  (rgba)
);
